### rtl/pcs_pkg.sv
`default_nettype none

package pcs_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 1024;
   localparam logic [31:0] RANGE_WIDTH_RESET = 32'd65536;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_BUILD  = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT = 2'd2;

   // Micro-operations that the controller issues to the datapath.
   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_APPEND,
      CMD_BUILD_EMPTY,
      CMD_BUILD_AGAIN,
      CMD_NOT_BUILT,
      CMD_MUL_INIT,
      CMD_MUL_STEP,
      CMD_INT_START,
      CMD_DIV_STEP,
      CMD_INT_END,
      CMD_ENT_RD,
      CMD_CDF_START,
      CMD_ENT_WR,
      CMD_BUILD_END,
      CMD_SRCH_INIT,
      CMD_SRCH_RD,
      CMD_SRCH_CMP,
      CMD_LO_RD,
      CMD_HI_RD,
      CMD_PDF_CAP,
      CMD_FRAC_START,
      CMD_FRAC_END,
      CMD_POS_START,
      CMD_POS_END
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       built;
      logic       mul_last;
      logic       div_last;
      logic       srch_done;
      logic       idx_last;
      logic       pdf_zero;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/pcs_ram.sv
`default_nettype none

module pcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/pcs_dp.sv
`default_nettype none

module pcs_dp #(
   parameter int MAX_ENTRIES = pcs_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pcs_pkg::cmd_type      cmd,
   output pcs_pkg::dp_status_type     stat,
   input  wire logic [1:0]            req_opcode,
   input  wire logic signed [31:0]    req_sample_value,
   input  wire logic [30:0]           req_uniform_u,
   input  wire logic                  csr_we,
   input  wire logic [31:0]           csr_wdata,
   output logic [1:0]                 rsp_status,
   output logic [9:0]                 rsp_segment_index,
   output logic [31:0]                rsp_position,
   output logic [31:0]                rsp_segment_pdf,
   output logic [47:0]                rsp_integral
);

   localparam int A_W    = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W  = 32 + A_W;
   localparam int R_W    = SUM_W + 1;
   localparam int PROD_W = SUM_W + 32;
   localparam int LO_W   = (SUM_W + 16 > CNT_W + 32) ? SUM_W + 16 : CNT_W + 32;
   localparam int Q_W    = LO_W + 1;
   localparam int DC_W   = $clog2(LO_W + 2);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);
   localparam logic [Q_W-1:0]   ONE_Q31   = Q_W'(1) << 31;

   logic [31:0]       rw_ff, rw_in;
   logic [1:0]        op_ff, op_in;
   logic [31:0]       v_ff, v_in;
   logic [30:0]       u_ff, u_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              built_ff, built_in;
   logic [47:0]       bint_ff, bint_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [9:0]        res_seg_ff, res_seg_in;
   logic [31:0]       res_pos_ff, res_pos_in;
   logic [31:0]       res_pdf_ff, res_pdf_in;
   logic [47:0]       res_int_ff, res_int_in;
   logic [PROD_W-1:0] mul_acc_ff, mul_acc_in;
   logic [31:0]       mul_b_ff, mul_b_in;
   logic [5:0]        mul_cnt_ff, mul_cnt_in;
   logic [R_W-1:0]    div_r_ff, div_r_in;
   logic [SUM_W-1:0]  div_den_ff, div_den_in;
   logic [LO_W-1:0]   div_lo_ff, div_lo_in;
   logic [Q_W-1:0]    div_q_ff, div_q_in;
   logic [DC_W-1:0]   div_cnt_ff, div_cnt_in;
   logic              div_first_ff, div_first_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  first_ff, first_in;
   logic [CNT_W-1:0]  size_ff, size_in;
   logic [CNT_W-1:0]  o_ff, o_in;
   logic [SUM_W-1:0]  lo_ff, lo_in;
   logic [SUM_W-1:0]  pdf_ff, pdf_in;
   logic [SUM_W-1:0]  du_ff, du_in;
   logic [31:0]       frac_ff, frac_in;

   logic              wr_en, rd_en;
   logic [A_W-1:0]    wr_addr, rd_addr;
   logic [SUM_W-1:0]  wr_data, rd_data;

   logic [31:0]       mag;
   logic [CNT_W-1:0]  half, mid, cnt_eff;
   logic [SUM_W-1:0]  sum_eff, hi_val, pdf_val, du_val;
   logic [R_W-1:0]    div_t, den_ext;
   logic              div_ge;
   logic [CNT_W+31:0] pos_num;

   pcs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      mag     = v_ff[31] ? (~v_ff + 32'd1) : v_ff;
      half    = size_ff >> 1;
      mid     = first_ff + half;
      cnt_eff = built_ff ? '0 : count_ff;
      sum_eff = built_ff ? '0 : sum_ff;
      den_ext = R_W'(div_den_ff);
      div_t   = div_first_ff ? div_r_ff : {div_r_ff[R_W-2:0], div_lo_ff[LO_W-1]};
      div_ge  = div_t >= den_ext;
      hi_val  = rd_data;
      pdf_val = (hi_val > lo_ff) ? hi_val - lo_ff : '0;
      du_val  = (SUM_W'(u_ff) > lo_ff) ? SUM_W'(u_ff) - lo_ff : '0;
      if (du_val > pdf_val) begin
         du_val = pdf_val;
      end
      pos_num = {o_ff, 32'd0} >> 1;
      pos_num = pos_num + (CNT_W + 32)'(frac_ff);
   end

   always_comb begin
      rw_in = csr_we ? csr_wdata : rw_ff;
      op_in = op_ff;  v_in = v_ff;  u_in = u_ff;
      count_in = count_ff;  sum_in = sum_ff;  built_in = built_ff;  bint_in = bint_ff;
      res_status_in = res_status_ff;  res_seg_in = res_seg_ff;
      res_pos_in = res_pos_ff;  res_pdf_in = res_pdf_ff;  res_int_in = res_int_ff;
      mul_acc_in = mul_acc_ff;  mul_b_in = mul_b_ff;  mul_cnt_in = mul_cnt_ff;
      div_r_in = div_r_ff;  div_den_in = div_den_ff;  div_lo_in = div_lo_ff;
      div_q_in = div_q_ff;  div_cnt_in = div_cnt_ff;  div_first_in = div_first_ff;
      idx_in = idx_ff;  first_in = first_ff;  size_in = size_ff;  o_in = o_ff;
      lo_in = lo_ff;  pdf_in = pdf_ff;  du_in = du_ff;  frac_in = frac_ff;
      wr_en = 1'b0;  wr_addr = idx_ff[A_W-1:0];  wr_data = SUM_W'(div_q_ff[31:0]);
      rd_en = 1'b0;  rd_addr = idx_ff[A_W-1:0];

      unique case (cmd)
         pcs_pkg::CMD_LOAD: begin
            op_in = req_opcode;
            v_in  = req_sample_value;
            u_in  = req_uniform_u;
            res_status_in = pcs_pkg::ST_OK;
            res_seg_in = '0;  res_pos_in = '0;  res_pdf_in = '0;  res_int_in = '0;
         end
         pcs_pkg::CMD_APPEND: begin
            // A built table is dropped before the new value starts a fresh one.
            built_in = 1'b0;
            count_in = cnt_eff;
            sum_in   = sum_eff;
            if (cnt_eff == MAX_COUNT) begin
               res_status_in = pcs_pkg::ST_FULL;
            end else begin
               sum_in   = sum_eff + SUM_W'(mag);
               count_in = cnt_eff + CNT_W'(1);
               wr_en    = 1'b1;
               wr_addr  = cnt_eff[A_W-1:0];
               wr_data  = sum_eff + SUM_W'(mag);
            end
         end
         pcs_pkg::CMD_BUILD_EMPTY, pcs_pkg::CMD_NOT_BUILT: begin
            res_status_in = pcs_pkg::ST_NOT_BUILT;
         end
         pcs_pkg::CMD_BUILD_AGAIN: begin
            res_int_in = bint_ff;
         end
         pcs_pkg::CMD_MUL_INIT: begin
            mul_acc_in = '0;
            mul_b_in   = rw_ff;
            mul_cnt_in = 6'd32;
         end
         pcs_pkg::CMD_MUL_STEP: begin
            mul_acc_in = (mul_acc_ff << 1) + (mul_b_ff[31] ? PROD_W'(sum_ff) : '0);
            mul_b_in   = mul_b_ff << 1;
            mul_cnt_in = mul_cnt_ff - 6'd1;
         end
         pcs_pkg::CMD_INT_START: begin
            div_r_in     = '0;
            div_den_in   = SUM_W'(count_ff);
            div_lo_in    = LO_W'(mul_acc_ff[PROD_W-1:16]);
            div_q_in     = '0;
            div_cnt_in   = DC_W'(LO_W + 1);
            div_first_in = 1'b1;
         end
         pcs_pkg::CMD_DIV_STEP: begin
            div_r_in     = div_ge ? div_t - den_ext : div_t;
            div_q_in     = {div_q_ff[Q_W-2:0], div_ge};
            div_lo_in    = div_first_ff ? div_lo_ff : div_lo_ff << 1;
            div_cnt_in   = div_cnt_ff - DC_W'(1);
            div_first_in = 1'b0;
         end
         pcs_pkg::CMD_INT_END: begin
            res_int_in = (|div_q_ff[Q_W-1:48]) ? '1 : div_q_ff[47:0];
            bint_in    = res_int_in;
            idx_in     = '0;
         end
         pcs_pkg::CMD_ENT_RD: begin
            rd_en = 1'b1;
         end
         pcs_pkg::CMD_CDF_START: begin
            if (sum_ff == '0 || rw_ff == '0) begin
               div_r_in   = R_W'(idx_ff) + R_W'(1);
               div_den_in = SUM_W'(count_ff);
            end else begin
               div_r_in   = R_W'(rd_data);
               div_den_in = sum_ff;
            end
            div_lo_in    = '0;
            div_q_in     = '0;
            div_cnt_in   = DC_W'(32);
            div_first_in = 1'b1;
         end
         pcs_pkg::CMD_ENT_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + CNT_W'(1);
         end
         pcs_pkg::CMD_BUILD_END: begin
            built_in = 1'b1;
         end
         pcs_pkg::CMD_SRCH_INIT: begin
            first_in = CNT_W'(1);
            size_in  = count_ff - CNT_W'(1);
         end
         pcs_pkg::CMD_SRCH_RD: begin
            rd_en   = 1'b1;
            rd_addr = A_W'(mid - CNT_W'(1));
         end
         pcs_pkg::CMD_SRCH_CMP: begin
            if (rd_data <= SUM_W'(u_ff)) begin
               first_in = mid + CNT_W'(1);
               size_in  = size_ff - half - CNT_W'(1);
            end else begin
               size_in = half;
            end
         end
         pcs_pkg::CMD_LO_RD: begin
            o_in    = first_ff - CNT_W'(1);
            rd_en   = 1'b1;
            rd_addr = A_W'(first_ff - CNT_W'(2));
         end
         pcs_pkg::CMD_HI_RD: begin
            lo_in   = (o_ff == '0) ? '0 : rd_data;
            rd_en   = 1'b1;
            rd_addr = o_ff[A_W-1:0];
         end
         pcs_pkg::CMD_PDF_CAP: begin
            pdf_in  = pdf_val;
            du_in   = du_val;
            frac_in = '0;
         end
         pcs_pkg::CMD_FRAC_START: begin
            div_r_in     = R_W'(du_ff);
            div_den_in   = pdf_ff;
            div_lo_in    = '0;
            div_q_in     = '0;
            div_cnt_in   = DC_W'(32);
            div_first_in = 1'b1;
         end
         pcs_pkg::CMD_FRAC_END: begin
            frac_in = div_q_ff[31:0];
         end
         pcs_pkg::CMD_POS_START: begin
            div_r_in     = '0;
            div_den_in   = SUM_W'(count_ff);
            div_lo_in    = LO_W'(pos_num);
            div_q_in     = '0;
            div_cnt_in   = DC_W'(LO_W + 1);
            div_first_in = 1'b1;
         end
         pcs_pkg::CMD_POS_END: begin
            res_pos_in = (div_q_ff > ONE_Q31) ? 32'h8000_0000 : div_q_ff[31:0];
            res_seg_in = 10'(o_ff);
            res_pdf_in = pdf_ff[31:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_ff    <= pcs_pkg::RANGE_WIDTH_RESET;
         count_ff <= '0;
         sum_ff   <= '0;
         built_ff <= 1'b0;
         bint_ff  <= '0;
      end else begin
         rw_ff    <= rw_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         built_ff <= built_in;
         bint_ff  <= bint_in;
      end
      op_ff <= op_in;  v_ff <= v_in;  u_ff <= u_in;
      res_status_ff <= res_status_in;  res_seg_ff <= res_seg_in;
      res_pos_ff <= res_pos_in;  res_pdf_ff <= res_pdf_in;  res_int_ff <= res_int_in;
      mul_acc_ff <= mul_acc_in;  mul_b_ff <= mul_b_in;  mul_cnt_ff <= mul_cnt_in;
      div_r_ff <= div_r_in;  div_den_ff <= div_den_in;  div_lo_ff <= div_lo_in;
      div_q_ff <= div_q_in;  div_cnt_ff <= div_cnt_in;  div_first_ff <= div_first_in;
      idx_ff <= idx_in;  first_ff <= first_in;  size_ff <= size_in;  o_ff <= o_in;
      lo_ff <= lo_in;  pdf_ff <= pdf_in;  du_ff <= du_in;  frac_ff <= frac_in;
   end

   always_comb begin
      stat.op         = op_ff;
      stat.count_zero = (count_ff == '0);
      stat.built      = built_ff;
      stat.mul_last   = (mul_cnt_ff == 6'd1);
      stat.div_last   = (div_cnt_ff == DC_W'(1));
      stat.srch_done  = (size_ff == '0);
      stat.idx_last   = (idx_ff == count_ff - CNT_W'(1));
      stat.pdf_zero   = (pdf_ff == '0);
   end

   assign rsp_status        = res_status_ff;
   assign rsp_segment_index = res_seg_ff;
   assign rsp_position      = res_pos_ff;
   assign rsp_segment_pdf   = res_pdf_ff;
   assign rsp_integral      = res_int_ff;

endmodule

`default_nettype wire

### rtl/pcs_ctrl.sv
`default_nettype none

module pcs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_valid,
   output pcs_pkg::cmd_type           cmd,
   input  wire pcs_pkg::dp_status_type stat
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_MUL, S_INT_START, S_INT_DIV, S_INT_END,
      S_CDF_RD, S_CDF_START, S_CDF_DIV, S_CDF_WR, S_BUILD_END,
      S_SRCH_CHK, S_SRCH_CMP, S_HI_RD, S_PDF, S_FRAC_START, S_FRAC_DIV,
      S_FRAC_END, S_POS_START, S_POS_DIV, S_POS_END, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = pcs_pkg::CMD_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd      = pcs_pkg::CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            if (stat.op == pcs_pkg::OP_APPEND) begin
               cmd = pcs_pkg::CMD_APPEND;
            end else if (stat.op == pcs_pkg::OP_BUILD) begin
               if (stat.count_zero) begin
                  cmd = pcs_pkg::CMD_BUILD_EMPTY;
               end else if (stat.built) begin
                  cmd = pcs_pkg::CMD_BUILD_AGAIN;
               end else begin
                  cmd      = pcs_pkg::CMD_MUL_INIT;
                  state_in = S_MUL;
               end
            end else if (stat.op == pcs_pkg::OP_SAMPLE) begin
               if (!stat.built || stat.count_zero) begin
                  cmd = pcs_pkg::CMD_NOT_BUILT;
               end else begin
                  cmd      = pcs_pkg::CMD_SRCH_INIT;
                  state_in = S_SRCH_CHK;
               end
            end
         end
         S_MUL: begin
            cmd = pcs_pkg::CMD_MUL_STEP;
            if (stat.mul_last) state_in = S_INT_START;
         end
         S_INT_START: begin
            cmd      = pcs_pkg::CMD_INT_START;
            state_in = S_INT_DIV;
         end
         S_INT_DIV: begin
            cmd = pcs_pkg::CMD_DIV_STEP;
            if (stat.div_last) state_in = S_INT_END;
         end
         S_INT_END: begin
            cmd      = pcs_pkg::CMD_INT_END;
            state_in = S_CDF_RD;
         end
         S_CDF_RD: begin
            cmd      = pcs_pkg::CMD_ENT_RD;
            state_in = S_CDF_START;
         end
         S_CDF_START: begin
            cmd      = pcs_pkg::CMD_CDF_START;
            state_in = S_CDF_DIV;
         end
         S_CDF_DIV: begin
            cmd = pcs_pkg::CMD_DIV_STEP;
            if (stat.div_last) state_in = S_CDF_WR;
         end
         S_CDF_WR: begin
            cmd      = pcs_pkg::CMD_ENT_WR;
            state_in = stat.idx_last ? S_BUILD_END : S_CDF_RD;
         end
         S_BUILD_END: begin
            cmd      = pcs_pkg::CMD_BUILD_END;
            state_in = S_RESP;
         end
         S_SRCH_CHK: begin
            if (stat.srch_done) begin
               cmd      = pcs_pkg::CMD_LO_RD;
               state_in = S_HI_RD;
            end else begin
               cmd      = pcs_pkg::CMD_SRCH_RD;
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            cmd      = pcs_pkg::CMD_SRCH_CMP;
            state_in = S_SRCH_CHK;
         end
         S_HI_RD: begin
            cmd      = pcs_pkg::CMD_HI_RD;
            state_in = S_PDF;
         end
         S_PDF: begin
            cmd      = pcs_pkg::CMD_PDF_CAP;
            state_in = S_FRAC_START;
         end
         S_FRAC_START: begin
            if (stat.pdf_zero) begin
               cmd      = pcs_pkg::CMD_POS_START;
               state_in = S_POS_DIV;
            end else begin
               cmd      = pcs_pkg::CMD_FRAC_START;
               state_in = S_FRAC_DIV;
            end
         end
         S_FRAC_DIV: begin
            cmd = pcs_pkg::CMD_DIV_STEP;
            if (stat.div_last) state_in = S_FRAC_END;
         end
         S_FRAC_END: begin
            cmd      = pcs_pkg::CMD_FRAC_END;
            state_in = S_POS_START;
         end
         S_POS_START: begin
            cmd      = pcs_pkg::CMD_POS_START;
            state_in = S_POS_DIV;
         end
         S_POS_DIV: begin
            cmd = pcs_pkg::CMD_DIV_STEP;
            if (stat.div_last) state_in = S_POS_END;
         end
         S_POS_END: begin
            cmd      = pcs_pkg::CMD_POS_END;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

`default_nettype wire

### rtl/piecewise_constant_sampler_top.sv
`default_nettype none

// Channel    Handshake                   Payload
// request    start, busy                 req_opcode, req_sample_value, req_uniform_u
// response   rsp_valid (one-cycle strobe) rsp_status, rsp_segment_index, rsp_position,
//                                        rsp_segment_pdf, rsp_integral
// csr        csr_valid, csr_ready        csr_wdata (range_width)
//
// One transaction is handled at a time. A build runs a serial multiply and the integral
// division, then converts each table entry in turn through the one-bit-per-cycle shared
// divider and the single RAM read port. A sample runs a binary search over the RAM
// (about log2(N) steps) and then two divisions; a zero-mass segment skips the fraction
// division. Reset is synchronous and clears the table; the CDF RAM itself is not
// cleared. The response cannot be stalled; busy drops in the cycle after the strobe,
// and register writes are held off while busy.

module piecewise_constant_sampler_top #(
   parameter int MAX_ENTRIES = pcs_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [31:0] req_sample_value,
   input  wire logic [30:0]        req_uniform_u,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [9:0]              rsp_segment_index,
   output logic [31:0]             rsp_position,
   output logic [31:0]             rsp_segment_pdf,
   output logic [47:0]             rsp_integral,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [31:0]        csr_wdata
);

   pcs_pkg::cmd_type       cmd;
   pcs_pkg::dp_status_type stat;

   // The range width feeds a build in flight, so it only changes while idle.
   assign csr_ready = ~busy;

   pcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   pcs_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_sample_value  (req_sample_value),
      .req_uniform_u     (req_uniform_u),
      .csr_we            (csr_valid & csr_ready),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_status),
      .rsp_segment_index (rsp_segment_index),
      .rsp_position      (rsp_position),
      .rsp_segment_pdf   (rsp_segment_pdf),
      .rsp_integral      (rsp_integral)
   );

endmodule

`default_nettype wire

### tb/tb_piecewise_constant_sampler_top.sv
`timescale 1ns / 100ps

module tb_piecewise_constant_sampler_top;

   localparam int NENT = pcs_pkg::MAX_ENTRIES_DEFAULT;
   // The stall limit leaves a wide margin over a full-table build.
   localparam int STALL_LIMIT = 200000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_opcode = pcs_pkg::OP_APPEND;
   logic signed [31:0] req_sample_value = '0;
   logic [30:0] req_uniform_u = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [9:0] rsp_segment_index;
   logic [31:0] rsp_position;
   logic [31:0] rsp_segment_pdf;
   logic [47:0] rsp_integral;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [31:0] csr_wdata = '0;

   piecewise_constant_sampler_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_sample_value(req_sample_value),
      .req_uniform_u(req_uniform_u), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_segment_index(rsp_segment_index), .rsp_position(rsp_position),
      .rsp_segment_pdf(rsp_segment_pdf), .rsp_integral(rsp_integral),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // One expected response of the block.
   typedef struct {
      logic [1:0]  status;
      logic [9:0]  seg;
      logic [31:0] pos;
      logic [31:0] pdf;
      logic [47:0] integ;
   } answer_type;

   answer_type pending_answers[$];
   int error_count = 0;
   int idle_cycles = 0;

   // Shadow copy of the table and the register.
   logic [63:0] shadow_cdf[NENT];
   logic [63:0] shadow_count;
   logic [63:0] shadow_sum;
   logic        shadow_built;
   logic [63:0] shadow_integral;
   logic [31:0] shadow_range;

   // (num << 31) / den for num <= den, computed the way the block does it.
   function automatic logic [63:0] q31_ratio(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = 0;
      r = num;
      if (r >= den) begin
         r = r - den;
         q = 1;
      end
      for (int b = 0; b < 31; b++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] boundary(logic [63:0] i);
      if (i == 0 || i > shadow_count) return 0;
      return shadow_cdf[i - 1];
   endfunction

   // Advances the shadow state by one accepted transaction and returns its answer.
   function automatic answer_type sampler_step(logic [1:0] op, logic [31:0] v,
                                               logic [30:0] u);
      answer_type a;
      logic [63:0] mag, n, pa, pb, size, first, half, mid, o, lo, hi, du, frac, uu;
      a = '{default: '0};
      n = shadow_count;
      uu = {33'd0, u};
      if (op == pcs_pkg::OP_APPEND) begin
         mag = v[31] ? {32'd0, -v} : {32'd0, v};
         if (shadow_built) begin
            shadow_count = 0;
            shadow_sum = 0;
            shadow_built = 1'b0;
         end
         if (shadow_count >= NENT) begin
            a.status = pcs_pkg::ST_FULL;
         end else begin
            shadow_sum = shadow_sum + mag;
            shadow_cdf[shadow_count] = shadow_sum;
            shadow_count = shadow_count + 1;
         end
      end else if (op == pcs_pkg::OP_BUILD) begin
         if (n == 0) begin
            a.status = pcs_pkg::ST_NOT_BUILT;
         end else if (shadow_built) begin
            a.integ = shadow_integral[47:0];
         end else begin
            pa = shadow_sum * {48'd0, shadow_range[31:16]};
            pb = shadow_sum * {48'd0, shadow_range[15:0]};
            shadow_integral = (pa + (pb >> 16)) / n;
            if (shadow_integral > 64'hFFFF_FFFF_FFFF) shadow_integral = 64'hFFFF_FFFF_FFFF;
            for (int i = 0; i < n; i++) begin
               if (shadow_sum == 0 || shadow_range == 0)
                  shadow_cdf[i] = ((i + 64'd1) << 31) / n;
               else
                  shadow_cdf[i] = q31_ratio(shadow_cdf[i], shadow_sum);
            end
            shadow_built = 1'b1;
            a.integ = shadow_integral[47:0];
         end
      end else if (op == pcs_pkg::OP_SAMPLE) begin
         if (!shadow_built || n == 0) begin
            a.status = pcs_pkg::ST_NOT_BUILT;
         end else begin
            size = n - 1;
            first = 1;
            while (size > 0) begin
               half = size >> 1;
               mid = first + half;
               if (boundary(mid) <= uu) begin
                  first = mid + 1;
                  size = size - half - 1;
               end else begin
                  size = half;
               end
            end
            o = first - 1;
            if (o > n - 1) o = n - 1;
            lo = boundary(o);
            hi = boundary(o + 1);
            a.pdf = (hi > lo) ? hi - lo : 0;
            du = (uu > lo) ? uu - lo : 0;
            frac = 0;
            if (hi > lo) begin
               if (du > hi - lo) du = hi - lo;
               frac = q31_ratio(du, hi - lo);
            end
            mid = ((o << 31) + frac) / n;
            if (mid > 64'h8000_0000) mid = 64'h8000_0000;
            a.pos = mid[31:0];
            a.seg = o[9:0];
         end
      end
      return a;
   endfunction

   // Sends one transaction after a random gap and records its expected answer.
   task automatic send_item(logic [1:0] op, logic [31:0] v, logic [30:0] u);
      int gap;
      gap = $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_sample_value <= v;
      req_uniform_u <= u;
      do @(posedge clock); while (busy);
      pending_answers = {pending_answers, sampler_step(op, v, u)};
   endtask

   // Holds the request side off until every outstanding answer is back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_answers.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_range(logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_range = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom_range(0, 65535);
         2: return -$urandom_range(0, 65535);
         default: return $urandom;
      endcase
   endfunction

   task automatic fill_table(int count);
      for (int i = 0; i < count; i++) send_item(pcs_pkg::OP_APPEND, pick_value(), '0);
   endtask

   task automatic sample_some(int count);
      for (int i = 0; i < count; i++) begin
         send_item(pcs_pkg::OP_SAMPLE, $urandom, 31'($urandom));
      end
   endtask

   // Empty table, unused opcode, field extremes, rebuild and append after build.
   task automatic test_directed();
      send_item(pcs_pkg::OP_SAMPLE, '0, 31'h7FFF_FFFF);
      send_item(pcs_pkg::OP_BUILD, '0, '0);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send_item(pcs_pkg::OP_APPEND, 32'h8000_0000, '0);
      send_item(pcs_pkg::OP_APPEND, 32'h7FFF_FFFF, '0);
      send_item(pcs_pkg::OP_APPEND, 32'd0, '0);
      send_item(pcs_pkg::OP_APPEND, 32'hFFFF_FFFF, '0);
      send_item(pcs_pkg::OP_SAMPLE, '0, 31'd5);
      send_item(pcs_pkg::OP_BUILD, '0, '0);
      send_item(pcs_pkg::OP_BUILD, '0, '0);
      send_item(pcs_pkg::OP_SAMPLE, '0, 31'd0);
      send_item(pcs_pkg::OP_SAMPLE, '0, 31'h7FFF_FFFF);
      send_item(pcs_pkg::OP_SAMPLE, '0, 31'h4000_0000);
      send_item(pcs_pkg::OP_SAMPLE, '0, 31'h3FFF_FFFF);
      send_item(pcs_pkg::OP_APPEND, 32'd65536, '0);
      send_item(pcs_pkg::OP_SAMPLE, '0, 31'd7);
      send_item(pcs_pkg::OP_BUILD, '0, '0);
      send_item(pcs_pkg::OP_SAMPLE, '0, 31'h1234_5678);
   endtask

   // An all-zero table and a zero range width both give a uniform CDF.
   task automatic test_uniform_fallback();
      fill_table(0);
      for (int i = 0; i < 5; i++) send_item(pcs_pkg::OP_APPEND, 32'd0, '0);
      send_item(pcs_pkg::OP_BUILD, '0, '0);
      sample_some(4);
      write_range(32'd0);
      send_item(pcs_pkg::OP_APPEND, 32'd100, '0);
      send_item(pcs_pkg::OP_APPEND, 32'd0, '0);
      send_item(pcs_pkg::OP_APPEND, -32'sd300, '0);
      send_item(pcs_pkg::OP_BUILD, '0, '0);
      sample_some(4);
   endtask

   // Fills the table to the last entry, then overflows it.
   task automatic test_table_full();
      send_item(pcs_pkg::OP_APPEND, 32'd1, '0);
      for (int i = 1; i < NENT; i++) send_item(pcs_pkg::OP_APPEND, $urandom, '0);
      send_item(pcs_pkg::OP_APPEND, 32'h7FFF_FFFF, '0);
      send_item(pcs_pkg::OP_APPEND, 32'h8000_0000, '0);
      send_item(pcs_pkg::OP_BUILD, '0, '0);
      sample_some(12);
      send_item(pcs_pkg::OP_APPEND, 32'd3, '0);
   endtask

   // Mostly well-formed tables with random content, with some random noise.
   task automatic test_random(int target);
      int sent;
      int n;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(2'($urandom), $urandom, 31'($urandom));
            sent++;
         end else begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
            fill_table(n);
            send_item(pcs_pkg::OP_BUILD, '0, '0);
            if ($urandom_range(0, 3) == 0) send_item(pcs_pkg::OP_BUILD, '0, '0);
            sample_some($urandom_range(1, 8));
            sent += n + 5;
         end
         if ($urandom_range(0, 40) == 0) drain();
      end
   endtask

   task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
         error_count++;
      end
   endtask

   // Every strobed response is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      answer_type w;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: response without a transaction, expected none, actual status %h",
                     $realtime, rsp_status);
            error_count++;
         end else begin
            w = pending_answers.pop_front();
            check_field("status", 48'(w.status), 48'(rsp_status));
            check_field("segment_index", 48'(w.seg), 48'(rsp_segment_index));
            check_field("position", 48'(w.pos), 48'(rsp_position));
            check_field("segment_pdf", 48'(w.pdf), 48'(rsp_segment_pdf));
            check_field("integral", w.integ, rsp_integral);
         end
      end
   end

   // The watchdog restarts on every accepted request, response or register write.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_piecewise_constant_sampler_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      shadow_count = 0;
      shadow_sum = 0;
      shadow_built = 1'b0;
      shadow_integral = 0;
      shadow_range = pcs_pkg::RANGE_WIDTH_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      // The sender waits here for every response before going on.
      drain();
      write_range(32'hFFFF_FFFF);
      test_directed();
      test_uniform_fallback();
      write_range(pcs_pkg::RANGE_WIDTH_RESET);
      test_table_full();
      write_range($urandom);
      test_random(300);
      write_range(32'd1);
      test_random(150);
      write_range(32'hFFFF_FFFF);
      test_random(200);

      drain();
      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_piecewise_constant_sampler_top: clean");
      end else begin
         $display("tb_piecewise_constant_sampler_top: errors");
      end
      $finish;
   end

endmodule
